// ----- design/rsi_pkg.sv -----
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared types and constants for the robot safety interlock.
// ----------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

  localparam int unsigned DutyW     = 8;
  localparam int unsigned CmdW      = 9;
  localparam int unsigned SpeedW    = 16;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned DebW      = 16;
  localparam int unsigned ReqW      = 6;
  localparam int unsigned PinW      = 4;
  localparam int unsigned TargetW   = 4;
  localparam int unsigned AddrW     = 3;
  localparam int unsigned DataW     = 32;

  localparam logic [DebW-1:0]    DebounceReset = DebW'(50);
  localparam logic [DutyW-1:0]   DutyMax       = DutyW'(255);
  localparam logic [TargetW-1:0] TargetMax     = TargetW'(5);

  // request bit positions
  localparam int unsigned ReqBuzzer  = 0;
  localparam int unsigned ReqLed     = 1;
  localparam int unsigned ReqVacuum  = 2;
  localparam int unsigned ReqRelay0  = 3;

  typedef enum logic [2:0] {
    OP_SAMPLE    = 3'd0,
    OP_SET_MOTOR = 3'd1,
    OP_STOP      = 3'd2,
    OP_SET_OUT   = 3'd3,
    OP_LATCH     = 3'd4
  } opcode_e;

  typedef enum logic [0:0] {
    REG_DEBOUNCE   = 1'b0,
    REG_RELAY_HIGH = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [DebW-1:0] debounce_ms;
    logic            relay_high;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [TimeW-1:0]   now_ms;
    logic               estop_button;
    logic               bumper_pressed;
    logic [PinW-1:0]    object_pins;
    logic [PinW-1:0]    floor_pins;
    logic [SpeedW-1:0]  left_speed;
    logic [SpeedW-1:0]  right_speed;
    logic [TargetW-1:0] target_output;
    logic               switch_on;
  } item_t;

  typedef struct packed {
    logic               estop_latch;
    logic               prev_button;
    logic [TimeW-1:0]   last_toggle_ms;
    logic               lock_set;
    logic [ReqW-1:0]    requests;
    logic [CmdW-1:0]    left_cmd;
    logic [CmdW-1:0]    right_cmd;
  } state_t;

  typedef struct packed {
    logic [DutyW-1:0] left_fwd;
    logic [DutyW-1:0] left_rev;
    logic [DutyW-1:0] right_fwd;
    logic [DutyW-1:0] right_rev;
    logic             buzzer_on;
    logic             led_on;
    logic             vacuum_on;
    logic [2:0]       relay_pins;
    logic             lock_active;
    logic             latch_state;
  } res_t;

endpackage : rsi_pkg

`default_nettype wire

// ----- design/rsi_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// rsi_cfg_regs
// APB-style configuration registers: debounce time and relay polarity.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_cfg_regs
  import rsi_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_DEBOUNCE:   cfg_d.debounce_ms = pwdata[DebW-1:0];
        REG_RELAY_HIGH: cfg_d.relay_high  = pwdata[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEBOUNCE:   prdata = {{(DataW-DebW){1'b0}}, cfg_q.debounce_ms};
      REG_RELAY_HIGH: prdata = {{(DataW-1){1'b0}}, cfg_q.relay_high};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms <= DebounceReset;
      cfg_q.relay_high  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule : rsi_cfg_regs

`default_nettype wire

// ----- design/rsi_core.sv -----
// ----------------------------------------------------------------------------
// rsi_core
// Next-state and result logic for one word: latch debounce, lock, motor
// commands, output requests and gated drive levels.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_core
  import rsi_pkg::*;
(
  input  item_t  item_i,
  input  state_t state_i,
  input  cfg_t   cfg_i,
  output state_t state_o,
  output res_t   res_o
);

  function automatic logic [CmdW-1:0] sat_speed(input logic [SpeedW-1:0] raw);
    logic signed [SpeedW-1:0] v;
    logic [CmdW-1:0]          r;
    begin
      v = signed'(raw);
      if (v > signed'(SpeedW'(DutyMax)))       r = CmdW'(DutyMax);
      else if (v < -signed'(SpeedW'(DutyMax))) r = CmdW'(-signed'(SpeedW'(DutyMax)));
      else                                      r = raw[CmdW-1:0];
      return r;
    end
  endfunction

  function automatic logic [DutyW-1:0] fwd_duty(input logic [CmdW-1:0] cmd);
    return (!cmd[CmdW-1] && (cmd != '0)) ? cmd[DutyW-1:0] : '0;
  endfunction

  function automatic logic [DutyW-1:0] rev_duty(input logic [CmdW-1:0] cmd);
    logic [CmdW-1:0] mag;
    begin
      mag = CmdW'(-cmd);
      return cmd[CmdW-1] ? mag[DutyW-1:0] : '0;
    end
  endfunction

  logic             rise;
  logic [TimeW-1:0] elapsed;
  logic             do_toggle;
  logic             new_latch;
  logic             new_lock;
  logic [ReqW-1:0]  live;
  logic [2:0]       want;

  assign rise      = item_i.estop_button && !state_i.prev_button;
  assign elapsed   = item_i.now_ms - state_i.last_toggle_ms;   // wraps mod 2^32
  assign do_toggle = rise && (elapsed > {{(TimeW-DebW){1'b0}}, cfg_i.debounce_ms});
  assign new_latch = state_i.estop_latch ^ do_toggle;
  assign new_lock  = new_latch || item_i.bumper_pressed
                  || (item_i.object_pins != '1) || (item_i.floor_pins != '0);

  always_comb begin
    state_o = state_i;
    unique case (item_i.opcode)
      OP_SAMPLE: begin
        state_o.estop_latch = new_latch;
        state_o.prev_button = item_i.estop_button;
        if (do_toggle) begin
          state_o.last_toggle_ms = item_i.now_ms;
        end
        state_o.lock_set = new_lock;
        if (new_lock) begin
          state_o.left_cmd  = '0;
          state_o.right_cmd = '0;
        end
      end
      OP_SET_MOTOR: begin
        if (state_i.lock_set) begin
          state_o.left_cmd  = '0;
          state_o.right_cmd = '0;
        end else begin
          state_o.left_cmd  = sat_speed(item_i.left_speed);
          state_o.right_cmd = sat_speed(item_i.right_speed);
        end
      end
      OP_STOP: begin
        state_o.left_cmd  = '0;
        state_o.right_cmd = '0;
      end
      OP_SET_OUT: begin
        if (item_i.target_output <= TargetMax) begin
          state_o.requests[item_i.target_output[2:0]] = item_i.switch_on;
        end
      end
      OP_LATCH: begin
        state_o.estop_latch = item_i.switch_on;
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

  assign live = state_o.lock_set ? '0 : state_o.requests;
  assign want = live[ReqRelay0 +: 3];

  always_comb begin
    res_o.left_fwd    = fwd_duty(state_o.left_cmd);
    res_o.left_rev    = rev_duty(state_o.left_cmd);
    res_o.right_fwd   = fwd_duty(state_o.right_cmd);
    res_o.right_rev   = rev_duty(state_o.right_cmd);
    res_o.buzzer_on   = state_o.requests[ReqBuzzer];
    res_o.led_on      = state_o.requests[ReqLed];
    res_o.vacuum_on   = live[ReqVacuum];
    res_o.relay_pins  = cfg_i.relay_high ? want : ~want;
    res_o.lock_active = state_o.lock_set;
    res_o.latch_state = state_o.estop_latch;
  end

endmodule : rsi_core

`default_nettype wire

// ----- design/robot_safety_interlock.sv -----
// ----------------------------------------------------------------------------
// robot_safety_interlock
// Safety interlock for a two-motor cleaning robot: e-stop latch with button
// debounce, lock from latch and sensors, gated motor duties and drives.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+----------------------------------
//  in      | in_valid_i / in_ready_o    | opcode_i .. switch_on_i
//  out     | out_valid_o / out_ready_i  | left_forward_duty_o .. latch_state_o
//  cfg     | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One word per cycle unless the output stalls; a word passes the input register,
// then the result register. All state updates in one pass of rsi_core.
// rst_ni clears state, valid flags and config (debounce 50, relays active low).
// A stalled output holds its word; the input register still takes a word
// while the result waits, then in_ready_o drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module robot_safety_interlock
  import rsi_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // config port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [AddrW-1:0]   paddr,
  input  wire logic [DataW-1:0]   pwdata,
  output logic      [DataW-1:0]   prdata,
  output logic                    pready,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         opcode_i,
  input  wire logic [TimeW-1:0]   now_ms_i,
  input  wire logic               estop_button_i,
  input  wire logic               bumper_pressed_i,
  input  wire logic [PinW-1:0]    object_pins_i,
  input  wire logic [PinW-1:0]    floor_pins_i,
  input  wire logic [SpeedW-1:0]  left_speed_i,
  input  wire logic [SpeedW-1:0]  right_speed_i,
  input  wire logic [TargetW-1:0] target_output_i,
  input  wire logic               switch_on_i,
  // output channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [DutyW-1:0]   left_forward_duty_o,
  output logic      [DutyW-1:0]   left_reverse_duty_o,
  output logic      [DutyW-1:0]   right_forward_duty_o,
  output logic      [DutyW-1:0]   right_reverse_duty_o,
  output logic                    buzzer_on_o,
  output logic                    led_on_o,
  output logic                    vacuum_on_o,
  output logic      [2:0]         relay_pins_o,
  output logic                    lock_active_o,
  output logic                    latch_state_o
);

  cfg_t   cfg;
  item_t  in_q;
  logic   in_valid_q;
  state_t state_q, state_d;
  res_t   res_d, res_q;
  logic   out_valid_q;
  logic   advance;

  rsi_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // stage 1 word moves to the result register
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q.opcode         <= opcode_i;
      in_q.now_ms         <= now_ms_i;
      in_q.estop_button   <= estop_button_i;
      in_q.bumper_pressed <= bumper_pressed_i;
      in_q.object_pins    <= object_pins_i;
      in_q.floor_pins     <= floor_pins_i;
      in_q.left_speed     <= left_speed_i;
      in_q.right_speed    <= right_speed_i;
      in_q.target_output  <= target_output_i;
      in_q.switch_on      <= switch_on_i;
    end
  end

  rsi_core u_core (
    .item_i  (in_q),
    .state_i (state_q),
    .cfg_i   (cfg),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign left_forward_duty_o  = res_q.left_fwd;
  assign left_reverse_duty_o  = res_q.left_rev;
  assign right_forward_duty_o = res_q.right_fwd;
  assign right_reverse_duty_o = res_q.right_rev;
  assign buzzer_on_o          = res_q.buzzer_on;
  assign led_on_o             = res_q.led_on;
  assign vacuum_on_o          = res_q.vacuum_on;
  assign relay_pins_o         = res_q.relay_pins;
  assign lock_active_o        = res_q.lock_active;
  assign latch_state_o        = res_q.latch_state;

`ifndef SYNTH
  // motors never run while locked
  a_lock_stops_motors: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.lock_active |->
      (res_q.left_fwd == '0) && (res_q.left_rev == '0) &&
      (res_q.right_fwd == '0) && (res_q.right_rev == '0))
    else $error("motor duty nonzero while locked");

  a_lock_gates_vacuum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.lock_active |-> !res_q.vacuum_on)
    else $error("vacuum on while locked");

  // a staged word that can move produces a result next cycle
  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && (!out_valid_q || out_ready_i) |=> out_valid_q)
    else $error("staged word lost");

  // held word keeps state unchanged
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without a word");
`endif

endmodule : robot_safety_interlock

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for robot_safety_interlock. Words go in through a valid/ready
// channel and each one is run through a local model of the interlock (e-stop
// debounce, lock, motor split, gated drives, relay polarity). Every result
// word is checked field by field against the oldest predicted one. Both
// channels idle at random, and one long output stall backs up the input.
// ----------------------------------------------------------------------------

module tb;
  import rsi_pkg::*;

  localparam logic [2:0]                OpFirstUnused = 3'd5;
  localparam int unsigned               IdlePct       = 28;
  localparam int unsigned               HoldCycles    = 60;
  localparam logic signed [SpeedW-1:0]  SpeedLimit    = SpeedW'(DutyMax);

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [AddrW-1:0]   paddr;
  logic [DataW-1:0]   pwdata;
  logic [DataW-1:0]   prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_ready_o;
  item_t              drv;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [DutyW-1:0]   left_forward_duty_o;
  logic [DutyW-1:0]   left_reverse_duty_o;
  logic [DutyW-1:0]   right_forward_duty_o;
  logic [DutyW-1:0]   right_reverse_duty_o;
  logic               buzzer_on_o;
  logic               led_on_o;
  logic               vacuum_on_o;
  logic [2:0]         relay_pins_o;
  logic               lock_active_o;
  logic               latch_state_o;

  // interlock model state and settings
  logic                     latch_q;
  logic                     prev_btn_q;
  logic [TimeW-1:0]         last_toggle_q;
  logic                     lock_q;
  logic [ReqW-1:0]          req_q;
  logic signed [CmdW-1:0]   lcmd_q;
  logic signed [CmdW-1:0]   rcmd_q;
  logic [DebW-1:0]          debounce_q;
  logic                     relay_high_q;

  res_t                     expected_q[$];
  int                       mismatches;
  int                       results_checked;
  int                       locked_results;
  int                       words_sent;
  int                       samples_sent;
  int                       motor_sets;
  int                       request_sets;
  int                       reg_writes;
  bit                       no_idle;
  int                       hold_request;
  logic [TimeW-1:0]         sim_ms;

  robot_safety_interlock dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .opcode_i             (drv.opcode),
    .now_ms_i             (drv.now_ms),
    .estop_button_i       (drv.estop_button),
    .bumper_pressed_i     (drv.bumper_pressed),
    .object_pins_i        (drv.object_pins),
    .floor_pins_i         (drv.floor_pins),
    .left_speed_i         (drv.left_speed),
    .right_speed_i        (drv.right_speed),
    .target_output_i      (drv.target_output),
    .switch_on_i          (drv.switch_on),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .left_forward_duty_o  (left_forward_duty_o),
    .left_reverse_duty_o  (left_reverse_duty_o),
    .right_forward_duty_o (right_forward_duty_o),
    .right_reverse_duty_o (right_reverse_duty_o),
    .buzzer_on_o          (buzzer_on_o),
    .led_on_o             (led_on_o),
    .vacuum_on_o          (vacuum_on_o),
    .relay_pins_o         (relay_pins_o),
    .lock_active_o        (lock_active_o),
    .latch_state_o        (latch_state_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // model
  // --------------------------------------------------------------------------
  function automatic logic signed [CmdW-1:0] clamp_speed(logic [SpeedW-1:0] raw);
    logic signed [SpeedW-1:0] s;
    s = raw;
    if (s > SpeedLimit) return CmdW'(SpeedLimit);
    if (s < -SpeedLimit) return CmdW'(-SpeedLimit);
    return s[CmdW-1:0];
  endfunction

  // {forward, reverse}
  function automatic logic [2*DutyW-1:0] split_cmd(logic signed [CmdW-1:0] c);
    logic signed [CmdW-1:0] mag;
    mag = -c;
    if (c > 0) return {c[DutyW-1:0], DutyW'(0)};
    if (c < 0) return {DutyW'(0), mag[DutyW-1:0]};
    return '0;
  endfunction

  function automatic res_t step_interlock(item_t w);
    res_t                r;
    logic [ReqW-1:0]     live;
    logic [2*DutyW-1:0]  lduty;
    logic [2*DutyW-1:0]  rduty;
    case (w.opcode)
      OP_SAMPLE: begin
        // debounce window is modulo 2^32
        if (w.estop_button && !prev_btn_q &&
            (w.now_ms - last_toggle_q) > TimeW'(debounce_q)) begin
          latch_q = ~latch_q;
          last_toggle_q = w.now_ms;
        end
        prev_btn_q = w.estop_button;
        lock_q = latch_q | w.bumper_pressed | (w.object_pins != '1) | (w.floor_pins != '0);
        if (lock_q) begin
          lcmd_q = '0;
          rcmd_q = '0;
        end
      end
      OP_SET_MOTOR: begin
        lcmd_q = clamp_speed(w.left_speed);
        rcmd_q = clamp_speed(w.right_speed);
        if (lock_q) begin
          lcmd_q = '0;
          rcmd_q = '0;
        end
      end
      OP_STOP: begin
        lcmd_q = '0;
        rcmd_q = '0;
      end
      OP_SET_OUT: begin
        if (w.target_output <= TargetMax) req_q[w.target_output[2:0]] = w.switch_on;
      end
      OP_LATCH: begin
        latch_q = w.switch_on;
      end
      default: ;
    endcase
    lduty = split_cmd(lcmd_q);
    rduty = split_cmd(rcmd_q);
    live = lock_q ? '0 : req_q;
    r.left_fwd    = lduty[2*DutyW-1:DutyW];
    r.left_rev    = lduty[DutyW-1:0];
    r.right_fwd   = rduty[2*DutyW-1:DutyW];
    r.right_rev   = rduty[DutyW-1:0];
    r.buzzer_on   = req_q[ReqBuzzer];
    r.led_on      = req_q[ReqLed];
    r.vacuum_on   = live[ReqVacuum];
    r.relay_pins  = relay_high_q ? live[ReqRelay0 +: 3] : ~live[ReqRelay0 +: 3];
    r.lock_active = lock_q;
    r.latch_state = latch_q;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // word builders
  // --------------------------------------------------------------------------
  function automatic item_t noise_word();
    item_t w;
    w.opcode         = 3'($urandom_range(0, 7));
    w.now_ms         = $urandom;
    w.estop_button   = 1'($urandom);
    w.bumper_pressed = 1'($urandom);
    w.object_pins    = PinW'($urandom);
    w.floor_pins     = PinW'($urandom);
    w.left_speed     = SpeedW'($urandom);
    w.right_speed    = SpeedW'($urandom);
    w.target_output  = TargetW'($urandom);
    w.switch_on      = 1'($urandom);
    return w;
  endfunction

  function automatic item_t sample_word(logic [TimeW-1:0] t, logic btn, logic bump,
                                        logic [PinW-1:0] obj, logic [PinW-1:0] flr);
    item_t w;
    w = noise_word();
    w.opcode         = OP_SAMPLE;
    w.now_ms         = t;
    w.estop_button   = btn;
    w.bumper_pressed = bump;
    w.object_pins    = obj;
    w.floor_pins     = flr;
    return w;
  endfunction

  function automatic item_t command_word(logic [2:0] op, logic [SpeedW-1:0] ls,
                                         logic [SpeedW-1:0] rs, logic [TargetW-1:0] tgt,
                                         logic on);
    item_t w;
    w = noise_word();
    w.opcode        = op;
    w.left_speed    = ls;
    w.right_speed   = rs;
    w.target_output = tgt;
    w.switch_on     = on;
    return w;
  endfunction

  // mostly plausible traffic: clean sensors and a clock that moves forward
  function automatic item_t random_word();
    item_t       w;
    int unsigned pick;
    w = noise_word();
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      w.opcode = OP_SAMPLE;
      if ($urandom_range(0, 99) < 85) begin
        sim_ms = sim_ms + TimeW'($urandom_range(0, 120));
        w.now_ms = sim_ms;
        w.bumper_pressed = ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 6) != 0) w.object_pins = '1;
        if ($urandom_range(0, 6) != 0) w.floor_pins = '0;
      end
    end else if (pick < 60) begin
      w.opcode = OP_SET_MOTOR;
      if ($urandom_range(0, 1) == 1) begin
        w.left_speed  = SpeedW'($urandom_range(0, 640)) - SpeedW'(320);
        w.right_speed = SpeedW'($urandom_range(0, 640)) - SpeedW'(320);
      end
    end else if (pick < 65) begin
      w.opcode = OP_STOP;
    end else if (pick < 83) begin
      w.opcode = OP_SET_OUT;
      if ($urandom_range(0, 99) < 85) w.target_output = TargetW'($urandom_range(0, 5));
    end else if (pick < 95) begin
      w.opcode = OP_LATCH;
    end else begin
      w.opcode = OpFirstUnused + 3'($urandom_range(0, 2));
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // channel and register access
  // --------------------------------------------------------------------------
  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input item_t w);
    while (!no_idle && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    drv        <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(step_interlock(w));
    words_sent++;
    case (w.opcode)
      OP_SAMPLE:    samples_sent++;
      OP_SET_MOTOR: motor_sets++;
      OP_SET_OUT:   request_sets++;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] val);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(idx) << 2;
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_DEBOUNCE) debounce_q = val[DebW-1:0];
    else relay_high_q = val[0];
    reg_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_motor_extremes();
    send_word(sample_word(32'd10, 1'b0, 1'b0, '1, '0));
    send_word(command_word(OP_SET_MOTOR, 16'h7FFF, 16'h8000, '0, 1'b0));
    send_word(command_word(OP_SET_MOTOR, 16'h0100, 16'hFF00, '0, 1'b0));
    send_word(command_word(OP_SET_MOTOR, 16'h0001, 16'hFFFF, '0, 1'b0));
    send_word(command_word(OP_SET_MOTOR, 16'h0000, 16'h0000, '0, 1'b0));
    send_word(command_word(OP_SET_MOTOR, 16'h00C8, 16'hFF38, '0, 1'b0));
    send_word(command_word(OP_STOP, 16'h00C8, 16'hFF38, '0, 1'b0));
  endtask

  task automatic test_output_requests();
    for (int t = 0; t < ReqW; t++) send_word(command_word(OP_SET_OUT, '0, '0, TargetW'(t), 1'b1));
    // out-of-range targets must not touch anything
    send_word(command_word(OP_SET_OUT, '0, '0, TargetMax + TargetW'(1), 1'b1));
    send_word(command_word(OP_SET_OUT, '0, '0, '1, 1'b1));
    send_word(command_word(OP_SET_OUT, '0, '0, TargetW'(ReqRelay0), 1'b0));
    send_word(command_word(OP_SET_OUT, '0, '0, TargetW'(ReqVacuum), 1'b0));
  endtask

  task automatic test_estop_latch();
    send_word(sample_word(32'd100, 1'b1, 1'b0, '1, '0));   // toggles on
    send_word(command_word(OP_SET_MOTOR, 16'd100, 16'd100, '0, 1'b0));
    send_word(sample_word(32'd110, 1'b0, 1'b0, '1, '0));
    send_word(sample_word(32'd130, 1'b1, 1'b0, '1, '0));   // inside debounce
    send_word(sample_word(32'd140, 1'b0, 1'b0, '1, '0));
    send_word(sample_word(32'd151, 1'b1, 1'b0, '1, '0));   // just past debounce
    send_word(sample_word(32'd160, 1'b0, 1'b1, '1, '0));
    send_word(sample_word(32'd170, 1'b0, 1'b0, 4'hE, '0));
    send_word(sample_word(32'd180, 1'b0, 1'b0, '1, 4'h8));
    send_word(command_word(OP_LATCH, '0, '0, '0, 1'b1));
    send_word(sample_word(32'd190, 1'b0, 1'b0, '1, '0));
    send_word(command_word(OP_LATCH, '0, '0, '0, 1'b0));
    // timestamp wraps: difference taken modulo 2^32
    send_word(sample_word(32'hFFFF_FFF0, 1'b1, 1'b0, '1, '0));
    send_word(sample_word(32'hFFFF_FFF8, 1'b0, 1'b0, '1, '0));
    send_word(sample_word(32'h0000_0020, 1'b1, 1'b0, '1, '0));
    for (int k = 0; k < 3; k++) send_word(command_word(OpFirstUnused + 3'(k), '1, '1, '1, 1'b1));
  endtask

  task automatic test_register_sweep();
    logic [DebW-1:0] deb;
    logic            rhigh;
    for (int i = 0; i < 5; i++) begin
      case (i)
        0:       begin deb = '0;                rhigh = 1'b1;        end
        1:       begin deb = '1;                rhigh = 1'b0;        end
        2:       begin deb = DebW'(1);          rhigh = 1'b1;        end
        3:       begin deb = DebW'($urandom);   rhigh = 1'($urandom); end
        default: begin deb = DebounceReset;     rhigh = 1'b0;        end
      endcase
      write_reg(REG_DEBOUNCE, DataW'(deb));
      write_reg(REG_RELAY_HIGH, DataW'(rhigh));
      if (i == 1) sim_ms = 32'hFFFF_FF00;
      repeat (60) send_word(random_word());
    end
  endtask

  task automatic test_random_traffic();
    sim_ms = $urandom;
    no_idle = 1'b1;
    repeat (150) send_word(random_word());
    no_idle = 1'b0;
    repeat (400) send_word(random_word());
  endtask

  task automatic test_output_stall();
    in_valid_i <= 1'b0;
    no_idle = 1'b1;
    @(posedge clk_i);
    hold_request = HoldCycles;
    @(negedge clk_i);
    repeat (24) send_word(random_word());
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // receiver and result check
  // --------------------------------------------------------------------------
  initial begin : ready_driver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (no_idle) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR %0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR %0t: result word with none expected", $time);
      end else begin
        want = expected_q.pop_front();
        check_field("left_forward_duty", 32'(want.left_fwd), 32'(left_forward_duty_o));
        check_field("left_reverse_duty", 32'(want.left_rev), 32'(left_reverse_duty_o));
        check_field("right_forward_duty", 32'(want.right_fwd), 32'(right_forward_duty_o));
        check_field("right_reverse_duty", 32'(want.right_rev), 32'(right_reverse_duty_o));
        check_field("buzzer_on", 32'(want.buzzer_on), 32'(buzzer_on_o));
        check_field("led_on", 32'(want.led_on), 32'(led_on_o));
        check_field("vacuum_on", 32'(want.vacuum_on), 32'(vacuum_on_o));
        check_field("relay_pins", 32'(want.relay_pins), 32'(relay_pins_o));
        check_field("lock_active", 32'(want.lock_active), 32'(lock_active_o));
        check_field("latch_state", 32'(want.latch_state), 32'(latch_state_o));
        results_checked++;
        if (want.lock_active) locked_results++;
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("Timeout: run did not complete, %0d results outstanding", expected_q.size());
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    drv          = '0;
    out_ready_i  = 1'b0;
    no_idle      = 1'b0;
    hold_request = 0;
    sim_ms       = '0;
    mismatches   = 0;
    results_checked = 0;
    locked_results  = 0;
    words_sent   = 0;
    samples_sent = 0;
    motor_sets   = 0;
    request_sets = 0;
    reg_writes   = 0;
    latch_q       = 1'b0;
    prev_btn_q    = 1'b0;
    last_toggle_q = '0;
    lock_q        = 1'b0;
    req_q         = '0;
    lcmd_q        = '0;
    rcmd_q        = '0;
    debounce_q    = DebounceReset;
    relay_high_q  = 1'b0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_motor_extremes();
    test_output_requests();
    test_estop_latch();
    test_register_sweep();
    test_random_traffic();
    test_output_stall();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      mismatches += expected_q.size();
      $display("ERROR: %0d expected results never arrived", expected_q.size());
    end

    $display("Covered %0d words (%0d samples, %0d motor sets, %0d output requests),",
             words_sent, samples_sent, motor_sets, request_sets);
    $display("  %0d reg writes; checked %0d results, %0d locked, a %0d-cycle output stall",
             reg_writes, results_checked, locked_results, HoldCycles);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- robot_safety_interlock.f -----
design/rsi_pkg.sv
design/rsi_cfg_regs.sv
design/rsi_core.sv
design/robot_safety_interlock.sv
test/tb.sv
